/* hdl/fan_tach_spinup_controller_assert.svh */
// Assertion macros shared by the fan tachometer controller modules.
`ifndef FAN_TACH_SPINUP_CONTROLLER_ASSERT_SVH
`define FAN_TACH_SPINUP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on clk, idle while rst_n is low.
`define FTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, idle while rst_n is low.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fts_pkg.sv */
// Shared types and constants of the fan tachometer controller.
package fts_pkg;

  // Function codes of an input word
  localparam logic [1:0] FUNC_TACH   = 2'd0;
  localparam logic [1:0] FUNC_PERIOD = 2'd1;
  localparam logic [1:0] FUNC_SETPT  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_IDX_DEBOUNCE = 3'd0;
  localparam logic [2:0] CFG_IDX_MIN_DUTY = 3'd1;
  localparam logic [2:0] CFG_IDX_MAX_DUTY = 3'd2;
  localparam logic [2:0] CFG_IDX_STALL    = 3'd3;
  localparam logic [2:0] CFG_IDX_SPINUP   = 3'd4;

  // Largest period length in ms
  localparam int unsigned DUR_MAX = 65535;

  typedef enum logic [1:0] {
    OP_TACH   = 2'd0,
    OP_PERIOD = 2'd1,
    OP_SETPT  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Classified command passed from the front end to the executor
  typedef struct packed {
    op_t         op;
    logic [31:0] now_us;
    logic [15:0] duration_ms;
    logic [6:0]  setpoint;
  } cmd_t;

  // Configuration register file
  typedef struct packed {
    logic [31:0] debounce_us;
    logic [6:0]  min_duty_percent;
    logic [6:0]  max_duty_percent;
    logic [15:0] stall_rpm;
    logic [15:0] spinup_ms;
  } cfg_t;

endpackage

/* hdl/fts_front.sv */
// Front end: takes input words, decodes the function and clamps the setpoint.
module fts_front import fts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_now_us,
  input  logic [15:0] in_duration_ms,
  input  logic [7:0]  in_duty_percent,
  input  logic [6:0]  min_duty_percent,
  input  logic [6:0]  max_duty_percent,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  logic       fe_valid_r;
  cmd_t       fe_cmd_r;
  cmd_t       cmd_dec;
  logic [7:0] clamp_hi;
  logic [7:0] clamp_lo;
  logic       take;

  // Clamp the requested setpoint into min..max, min winning when they cross
  always_comb begin
    clamp_hi = (in_duty_percent < {1'b0, max_duty_percent}) ?
               in_duty_percent : {1'b0, max_duty_percent};
    clamp_lo = (clamp_hi > {1'b0, min_duty_percent}) ?
               clamp_hi : {1'b0, min_duty_percent};
  end

  // Decode the function code
  always_comb begin
    cmd_dec.now_us      = in_now_us;
    cmd_dec.duration_ms = in_duration_ms;
    cmd_dec.setpoint    = clamp_lo[6:0];
    case (in_func)
      FUNC_TACH:   cmd_dec.op = OP_TACH;
      FUNC_PERIOD: cmd_dec.op = OP_PERIOD;
      FUNC_SETPT:  cmd_dec.op = OP_SETPT;
      default:     cmd_dec.op = OP_NOP;
    endcase
  end

  // Hold a decoded word until the queue has room
  assign q_push   = fe_valid_r && !q_full;
  assign q_data   = fe_cmd_r;
  assign in_stall = fe_valid_r && q_full;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else if (take) begin
      fe_valid_r <= 1'b1;
    end else if (q_push) begin
      fe_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fe_cmd_r <= cmd_dec;
    end
  end

endmodule

/* hdl/fts_fifo.sv */
// Command queue between the front end and the executor.
module fts_fifo import fts_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  cmd_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output cmd_t q_rdata,
  output logic q_empty
);

  `include "fan_tach_spinup_controller_assert.svh"

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign q_full  = (count_r == CntFull);
  assign q_empty = (count_r == '0);
  assign q_rdata = mem_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (q_pop && !q_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `FTS_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "push into a full queue")
  `FTS_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_empty, "pop from an empty queue")

endmodule

/* hdl/fts_div.sv */
// Restoring divider, one quotient bit per cycle.
module fts_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             div_start,
  input  logic [NUM_W-1:0] div_num,
  input  logic [DEN_W-1:0] div_den,
  output logic             div_done,
  output logic [NUM_W-1:0] div_quot
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtract of one step
  always_comb begin
    shifted = {rem_r, num_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
  end

  assign div_done = done_r;
  assign div_quot = num_r;

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient in behind the dividend
  always_ff @(posedge clk) begin
    if (div_start) begin
      num_r <= div_num;
      den_r <= div_den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

/* hdl/fts_back.sv */
// Executor: pulse counting, speed measurement, spin-up timer and drive duty.
module fts_back import fts_pkg::*; #(
  parameter int unsigned PULSES_PER_REV = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_rpm,
  output logic [7:0]  out_duty_code,
  output logic        out_blocked
);

  `include "fan_tach_spinup_controller_assert.svh"

  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = $clog2(PULSES_PER_REV * DUR_MAX + 1);
  localparam logic [15:0] RpmScale = 16'd60000;
  localparam logic [12:0] Recip100 = 13'd5243;   // 2^19 / 100, rounded up

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_WAIT,
    S_SPIN,
    S_DUTY,
    S_RESULT
  } state_t;

  state_t          state_r;
  cmd_t            cmd_r;
  logic [15:0]     pulse_count_r;
  logic [31:0]     last_bounce_r;
  logic [15:0]     rpm_r;
  logic [15:0]     spin_left_r;
  logic [6:0]      setpoint_r;
  logic [7:0]      duty_r;
  logic [NumW-1:0] prod_r;
  logic [DenW-1:0] den_r;
  logic            out_valid_r;
  logic [15:0]     out_rpm_r;
  logic [7:0]      out_duty_r;
  logic            out_blocked_r;

  logic            div_start;
  logic            div_done;
  logic [NumW-1:0] div_quot;
  logic [31:0]     interval;
  logic [15:0]     spin_load;
  logic [15:0]     spin_nxt;
  logic [6:0]      pct;
  logic [7:0]      duty_nxt;
  logic            out_free;
  logic            issue;

  // Map percent to the 0..255 scale: floor(pct*255/100), saturating
  function automatic logic [7:0] pct_to_code(input logic [6:0] p);
    logic [14:0] scaled;
    logic [27:0] prod;
    logic [8:0]  q;
    scaled = {p, 8'd0} - {8'd0, p};
    prod   = 28'(scaled) * 28'(Recip100);
    q      = prod[27:19];
    return (q > 9'd255) ? 8'd255 : q[7:0];
  endfunction

  fts_div #(
    .NUM_W (NumW),
    .DEN_W (DenW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .div_num   (prod_r),
    .div_den   (den_r),
    .div_done  (div_done),
    .div_quot  (div_quot)
  );

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_start = (state_r == S_START);
  assign interval  = cmd_r.now_us - last_bounce_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = (state_r == S_RESULT) && out_free;

  // Stall check and countdown of the spin-up timer
  always_comb begin
    spin_load = ((rpm_r <= cfg.stall_rpm) && (setpoint_r >= cfg.min_duty_percent)) ?
                cfg.spinup_ms : spin_left_r;
    spin_nxt  = spin_load;
    if ((spin_load != 16'd0) && (rpm_r >= cfg.stall_rpm)) begin
      spin_nxt = (spin_load > cmd_r.duration_ms) ? spin_load - cmd_r.duration_ms : 16'd0;
    end
  end

  // Pick the drive percent
  always_comb begin
    pct      = (spin_left_r != 16'd0) ? cfg.max_duty_percent : setpoint_r;
    duty_nxt = pct_to_code(pct);
  end

  // Sequence one command at a time, hold state and the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pulse_count_r <= '0;
      last_bounce_r <= '0;
      rpm_r         <= '0;
      spin_left_r   <= '0;
      setpoint_r    <= '0;
      duty_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Raise valid on issue, drop it once the word is taken
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_rdata;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RESULT;
          case (cmd_r.op)
            OP_TACH: begin
              if (interval >= cfg.debounce_us) begin
                if (pulse_count_r != 16'hFFFF) begin
                  pulse_count_r <= pulse_count_r + 16'd1;
                end
              end else begin
                last_bounce_r <= cmd_r.now_us;
              end
            end
            OP_PERIOD: begin
              prod_r        <= pulse_count_r * RpmScale;
              den_r         <= DenW'(PULSES_PER_REV) * DenW'(cmd_r.duration_ms);
              pulse_count_r <= '0;
              last_bounce_r <= '0;
              if (cmd_r.duration_ms == 16'd0) begin
                rpm_r   <= 16'hFFFF;
                state_r <= S_SPIN;
              end else begin
                state_r <= S_START;
              end
            end
            OP_SETPT: begin
              setpoint_r <= cmd_r.setpoint;
            end
            default: begin
            end
          endcase
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            rpm_r   <= (|div_quot[NumW-1:16]) ? 16'hFFFF : div_quot[15:0];
            state_r <= S_SPIN;
          end
        end
        S_SPIN: begin
          spin_left_r <= spin_nxt;
          state_r     <= S_DUTY;
        end
        S_DUTY: begin
          duty_r  <= duty_nxt;
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_rpm_r     <= rpm_r;
            out_duty_r    <= duty_r;
            out_blocked_r <= (spin_left_r != 16'd0);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rpm       = out_rpm_r;
  assign out_duty_code = out_duty_r;
  assign out_blocked   = out_blocked_r;

  `FTS_ASSERT_IMPL(a_done_in_wait, div_done, state_r == S_WAIT, "divider done outside wait")
  `FTS_ASSERT_IMPL(a_pop_in_idle, q_pop, state_r == S_IDLE, "queue pop while busy")
  `FTS_ASSERT_NEXT(a_result_out, (state_r == S_RESULT) && out_free, out_valid_r && (state_r == S_IDLE), "result word not issued")

endmodule

/* hdl/fan_tach_spinup_controller.sv */
// Top level of the four-wire fan tachometer and spin-up controller.
//
// Input channel (in_valid / in_stall): one word per event. in_func selects a
// tachometer edge (in_now_us), the end of a measuring period (in_duration_ms)
// or a new duty setpoint (in_duty_percent). Every word yields exactly one
// output word (out_valid / out_stall) carrying the speed in rpm, the drive
// duty code on 0..255 and the spin-up blocked flag after that event.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written by the user
// only while idle; the block itself does not enforce it.
//
// Words pass an input register and a command queue before the executor, so
// input is taken while a result waits on a stalled receiver. The executor
// works one word at a time: edges, setpoints and unused codes pass its exec
// and result states to the output register; a period end with nonzero length
// also passes start, the wait on the 32-step serial divider for the rpm
// quotient, spin and duty; a zero-length period skips the divider.
// A stalled output holds its word and the executor waits behind it; input
// stalls once the queue and input register are full.
// Reset (rst_n low, synchronous) clears counts, speed, timer, setpoint and
// duty to zero and loads the register defaults.
module fan_tach_spinup_controller import fts_pkg::*; #(
  parameter int unsigned PULSES_PER_REV = 2,
  parameter int unsigned QUEUE_DEPTH    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_now_us,
  input  logic [15:0] in_duration_ms,
  input  logic [7:0]  in_duty_percent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_rpm,
  output logic [7:0]  out_duty_code,
  output logic        out_blocked,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_us      <= 32'd0;
      cfg_r.min_duty_percent <= 7'd20;
      cfg_r.max_duty_percent <= 7'd100;
      cfg_r.stall_rpm        <= 16'd0;
      cfg_r.spinup_ms        <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_DEBOUNCE: cfg_r.debounce_us      <= cfg_wdata;
        CFG_IDX_MIN_DUTY: cfg_r.min_duty_percent <= cfg_wdata[6:0];
        CFG_IDX_MAX_DUTY: cfg_r.max_duty_percent <= cfg_wdata[6:0];
        CFG_IDX_STALL:    cfg_r.stall_rpm        <= cfg_wdata[15:0];
        CFG_IDX_SPINUP:   cfg_r.spinup_ms        <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  fts_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_now_us        (in_now_us),
    .in_duration_ms   (in_duration_ms),
    .in_duty_percent  (in_duty_percent),
    .min_duty_percent (cfg_r.min_duty_percent),
    .max_duty_percent (cfg_r.max_duty_percent),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  fts_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  fts_back #(
    .PULSES_PER_REV (PULSES_PER_REV)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rpm       (out_rpm),
    .out_duty_code (out_duty_code),
    .out_blocked   (out_blocked)
  );

endmodule

/* tb/fan_tach_spinup_checker.sv */
// Status word predictor and comparator for the fan tachometer controller.
module fan_tach_spinup_checker
  import fts_pkg::*;
#(
  parameter int unsigned PULSES_PER_REV = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_now_us,
  input  logic [15:0] in_duration_ms,
  input  logic [7:0]  in_duty_percent,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_rpm,
  input  logic [7:0]  out_duty_code,
  input  logic        out_blocked,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatch_count,
  output int          pending_count,
  output int          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam cfg_t CFG_RESET = '{
    debounce_us:      32'd0,
    min_duty_percent: 7'd20,
    max_duty_percent: 7'd100,
    stall_rpm:        16'd0,
    spinup_ms:        16'd1000
  };

  typedef struct packed {
    logic [15:0] rpm;
    logic [7:0]  duty_code;
    logic        blocked;
  } fan_status_t;

  // Shadow copy of the registers and of the controller state
  cfg_t        regs;
  logic [15:0] tach_pulses;
  logic [31:0] bounce_stamp;
  logic [15:0] speed_rpm;
  logic [15:0] spinup_left;
  logic [6:0]  setpoint;
  logic [7:0]  drive_code;
  fan_status_t status_q[$];
  fan_status_t want;

  // Map percent onto the 0..255 drive scale, saturating above 100 percent
  function automatic logic [7:0] drive_from_percent(input logic [6:0] pct);
    int unsigned code;
    code = pct * 255 / 100;
    return (code > 255) ? 8'hFF : code[7:0];
  endfunction

  // Close a measuring period: speed, stall detection, spin-up countdown, duty
  task automatic end_period(input logic [15:0] dur);
    longint unsigned num;
    longint unsigned den;
    longint unsigned quot;
    logic [6:0]      pct;
    num          = 64'(tach_pulses) * 64'd60000;
    den          = 64'(PULSES_PER_REV) * 64'(dur);
    tach_pulses  = '0;
    bounce_stamp = '0;
    if (dur == 0) begin
      speed_rpm = 16'hFFFF;
    end else begin
      quot      = num / den;
      speed_rpm = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
    end
    if (speed_rpm <= regs.stall_rpm && setpoint >= regs.min_duty_percent) begin
      spinup_left = regs.spinup_ms;
    end
    if (spinup_left != 0 && speed_rpm >= regs.stall_rpm) begin
      spinup_left = (spinup_left > dur) ? spinup_left - dur : 16'd0;
    end
    pct        = (spinup_left != 0) ? regs.max_duty_percent : setpoint;
    drive_code = drive_from_percent(pct);
  endtask

  // Advance the shadow state by one input word and queue the status it yields
  task automatic apply_word(input logic [1:0] func, input logic [31:0] now,
                            input logic [15:0] dur, input logic [7:0] req);
    logic [31:0] interval;
    logic [7:0]  capped;
    case (op_t'(func))
      OP_TACH: begin
        interval = now - bounce_stamp;
        if (interval >= regs.debounce_us) begin
          if (tach_pulses != 16'hFFFF) tach_pulses = tach_pulses + 16'd1;
        end else begin
          bounce_stamp = now;
        end
      end
      OP_PERIOD: end_period(dur);
      OP_SETPT: begin
        capped   = (req < {1'b0, regs.max_duty_percent}) ? req : {1'b0, regs.max_duty_percent};
        capped   = (capped > {1'b0, regs.min_duty_percent}) ? capped
                                                            : {1'b0, regs.min_duty_percent};
        setpoint = capped[6:0];
      end
      default: ;
    endcase
    status_q.push_back('{rpm: speed_rpm, duty_code: drive_code, blocked: spinup_left != 0});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs           = CFG_RESET;
      tach_pulses    = '0;
      bounce_stamp   = '0;
      speed_rpm      = '0;
      spinup_left    = '0;
      setpoint       = '0;
      drive_code     = '0;
      mismatch_count = 0;
      checked_count  = 0;
      status_q.delete();
    end else begin
      // Compare the outgoing word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%t unexpected status word: rpm %0d duty %0d blocked %0b",
                     $realtime, out_rpm, out_duty_code, out_blocked);
          end
          mismatch_count++;
        end else begin
          want = status_q.pop_front();
          checked_count++;
          if (out_rpm !== want.rpm || out_duty_code !== want.duty_code ||
              out_blocked !== want.blocked) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%t status mismatch: expected rpm %0d duty %0d blocked %0b, got rpm %0d duty %0d blocked %0b",
                       $realtime, want.rpm, want.duty_code, want.blocked,
                       out_rpm, out_duty_code, out_blocked);
            end
            mismatch_count++;
          end
        end
      end
      // Predict from the incoming word
      if (in_valid && !in_stall) begin
        apply_word(in_func, in_now_us, in_duration_ms, in_duty_percent);
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_DEBOUNCE: regs.debounce_us      = cfg_wdata;
          CFG_IDX_MIN_DUTY: regs.min_duty_percent = cfg_wdata[6:0];
          CFG_IDX_MAX_DUTY: regs.max_duty_percent = cfg_wdata[6:0];
          CFG_IDX_STALL:    regs.stall_rpm        = cfg_wdata[15:0];
          CFG_IDX_SPINUP:   regs.spinup_ms        = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    pending_count = status_q.size();
  end

endmodule

/* tb/tb_fan_tach_spinup_controller.sv */
// Testbench top for the fan tachometer controller: stimulus, stall patterns and verdict.
module tb_fan_tach_spinup_controller;
  import fts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_WORDS  = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func         = FUNC_TACH;
  logic [31:0] in_now_us       = '0;
  logic [15:0] in_duration_ms  = '0;
  logic [7:0]  in_duty_percent = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [15:0] out_rpm;
  logic [7:0]  out_duty_code;
  logic        out_blocked;
  logic        cfg_we          = 1'b0;
  logic [2:0]  cfg_index       = CFG_IDX_DEBOUNCE;
  logic [31:0] cfg_wdata       = '0;

  int mismatch_count;
  int pending_count;
  int checked_count;

  // Traffic shaping knobs and run statistics
  int          src_idle_pct     = 0;
  int          sink_stall_pct   = 0;
  int          hold_asks        = 0;
  int          holds_taken      = 0;
  int          hold_left        = 0;
  int          quiet_cycles     = 0;
  logic [31:0] cur_debounce     = '0;
  logic [15:0] cur_stall        = '0;
  int          words_sent       = 0;
  int          periods_sent     = 0;
  int          setpoints_sent   = 0;
  int          settings_applied = 0;

  fan_tach_spinup_controller dut (.*);

  fan_tach_spinup_checker status_check (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Drive the result-side stall: a long hold-off when asked, else random per mix
  always @(posedge clk) begin
    if (hold_asks != holds_taken) begin
      holds_taken = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Stop the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_fan_tach_spinup_controller: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, hold it until taken, then maybe idle for a random gap
  task automatic put_word(input logic [1:0] func, input logic [31:0] now,
                          input logic [15:0] dur, input logic [7:0] duty);
    int gap;
    in_valid        <= 1'b1;
    in_func         <= func;
    in_now_us       <= now;
    in_duration_ms  <= dur;
    in_duty_percent <= duty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (func == FUNC_PERIOD) periods_sent++;
    else if (func == FUNC_SETPT) setpoints_sent++;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted status word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_count != 0);
  endtask

  // Write all five registers back to back; narrow ones get junk in the upper bits
  task automatic apply_setting(input logic [31:0] deb, input logic [6:0] lo_pct, hi_pct,
                               input logic [15:0] stall_lim, spin_ms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_IDX_MIN_DUTY;
    cfg_wdata <= {25'($urandom()), lo_pct};
    @(posedge clk);
    cfg_index <= CFG_IDX_MAX_DUTY;
    cfg_wdata <= {25'($urandom()), hi_pct};
    @(posedge clk);
    cfg_index <= CFG_IDX_STALL;
    cfg_wdata <= {16'($urandom()), stall_lim};
    @(posedge clk);
    cfg_index <= CFG_IDX_SPINUP;
    cfg_wdata <= {16'($urandom()), spin_ms};
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_debounce = deb;
    cur_stall    = stall_lim;
    settings_applied++;
  endtask

  // Setpoint request, mostly near the legal percent range
  function automatic logic [7:0] pick_percent();
    if ($urandom_range(3) == 0) return 8'($urandom());
    return 8'($urandom_range(120));
  endfunction

  // Period length, mostly aimed so the speed lands close to the stall limit
  function automatic logic [15:0] pick_duration(input int unsigned pulses);
    int unsigned target;
    int unsigned d;
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom());
      3: return 16'($urandom_range(1, 20));
      default: begin
        target = (cur_stall == 0) ? $urandom_range(1, 400) : cur_stall;
        d = pulses * 30000 / target + $urandom_range(1);
        if (d == 0) d = 1;
        if (d > 65535) d = 65535;
        return 16'(d);
      end
    endcase
  endfunction

  // Mostly whole measuring periods (edges then period end), some loose noise
  task automatic run_traffic(input int n_words);
    int          sent;
    int          edges;
    logic [1:0]  func;
    logic [31:0] stamp;
    logic [31:0] step;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(3) == 0) begin
          put_word(FUNC_SETPT, $urandom(), 16'($urandom()), pick_percent());
          sent++;
        end
        edges = $urandom_range(24);
        stamp = $urandom();
        repeat (edges) begin
          case ($urandom_range(3))
            0:       step = cur_debounce;
            1:       step = cur_debounce - 32'd1;
            2:       step = cur_debounce + $urandom_range(50);
            default: step = $urandom();
          endcase
          stamp = stamp + step;
          put_word(FUNC_TACH, stamp, 16'($urandom()), 8'($urandom()));
          sent++;
        end
        put_word(FUNC_PERIOD, $urandom(), pick_duration(edges), 8'($urandom()));
        sent++;
      end else begin
        func = 2'($urandom_range(3));
        put_word(func, $urandom(), pick_duration($urandom_range(24)), 8'($urandom()));
        if (func != OP_NOP) sent++;
      end
    end
  endtask

  // One register setting under one idle/stall mix, with a full drain halfway
  task automatic run_phase(input int src_pct, sink_pct, input logic [31:0] deb,
                           input logic [6:0] lo_pct, hi_pct,
                           input logic [15:0] stall_lim, spin_ms, input bit with_hold);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    apply_setting(deb, lo_pct, hi_pct, stall_lim, spin_ms);
    if (with_hold) hold_asks++;
    run_traffic(PHASE_WORDS / 2);
    drain();
    run_traffic(PHASE_WORDS / 2);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: zero period, unused code, clamp ends, speed saturation, timer floor
    put_word(FUNC_PERIOD, '0, 16'd0, '0);
    put_word(OP_NOP, '1, '1, '1);
    put_word(FUNC_SETPT, '0, '0, 8'd0);
    put_word(FUNC_SETPT, '0, '0, 8'd255);
    put_word(FUNC_SETPT, '0, '0, 8'd50);
    put_word(FUNC_TACH, 32'd0, '0, '0);
    put_word(FUNC_TACH, 32'hFFFF_FFFF, '0, '0);
    put_word(FUNC_TACH, 32'd12345, '0, '0);
    put_word(FUNC_PERIOD, '0, 16'd1, '0);
    put_word(FUNC_PERIOD, '0, 16'hFFFF, '0);
    put_word(FUNC_PERIOD, '0, 16'd0, '0);
    drain();

    // Minimum above maximum, widest debounce with wrapped intervals, stall at the limit
    apply_setting(32'hFFFF_FFFF, 7'd60, 7'd30, 16'd300, 16'hFFFF);
    put_word(FUNC_SETPT, '0, '0, 8'd10);
    put_word(FUNC_PERIOD, '0, 16'd100, '0);
    put_word(FUNC_TACH, 32'hFFFF_FFFF, '0, '0);
    put_word(FUNC_TACH, 32'd5, '0, '0);
    put_word(FUNC_TACH, 32'd4, '0, '0);
    put_word(FUNC_PERIOD, '0, 16'd200, '0);
    put_word(FUNC_PERIOD, '0, 16'hFFFF, '0);
    drain();

    // Duty code overflow above 100 percent, stall limit at its top
    apply_setting(32'd7, 7'd0, 7'd127, 16'hFFFF, 16'd1);
    put_word(FUNC_SETPT, '0, '0, 8'd127);
    put_word(FUNC_PERIOD, '0, 16'd50, '0);
    put_word(FUNC_TACH, 32'd3, '0, '0);
    put_word(FUNC_TACH, 32'd10, '0, '0);
    put_word(FUNC_PERIOD, '0, 16'hFFFF, '0);
    put_word(FUNC_PERIOD, '0, 16'd0, '0);
    drain();

    // Random periods under each idle/stall mix and a spread of settings
    run_phase(0, 0, 32'd0, 7'd0, 7'd100, 16'd0, 16'd0, 1'b1);
    run_phase(0, 0, 32'hFFFF_FFFF, 7'd100, 7'd100, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(80, 0, 32'd500, 7'd20, 7'd80, 16'd300, 16'd1000, 1'b0);
    run_phase(80, 0, $urandom(), 7'd60, 7'd30, 16'd1500, 16'd200, 1'b0);
    run_phase(0, 80, 32'd50, 7'd0, 7'd0, 16'd1, 16'd1, 1'b1);
    run_phase(0, 80, 32'd1000, 7'd10, 7'd127, 16'd600, 16'd5000, 1'b0);
    run_phase(16, 16, $urandom_range(2000), 7'($urandom_range(100)),
              7'($urandom_range(100)), 16'($urandom_range(3000)), 16'($urandom()), 1'b0);
    run_phase(16, 16, $urandom_range(2000), 7'($urandom_range(100)),
              7'($urandom_range(100)), 16'($urandom_range(3000)), 16'($urandom()), 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d period ends, %0d setpoint writes), %0d status words checked",
             words_sent, periods_sent, setpoints_sent, checked_count);
    $display("over %0d register settings, four idle/stall mixes and long output hold-offs",
             settings_applied);
    if (pending_count != 0) $display("%0d predicted status words never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_fan_tach_spinup_controller: done, clean");
    end else begin
      $display("tb_fan_tach_spinup_controller: done, errors");
    end
    $finish;
  end

endmodule
